// ===== hw/rtl/cau_pkg.sv =====
`timescale 1ns / 1ps

package cau_pkg;

   localparam int WordBitsDef = 32;
   localparam int FracBitsDef = 16;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_CMP = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

endpackage

// ===== hw/rtl/cau_div_step.sv =====
`timescale 1ns / 1ps

module cau_div_step #(
   parameter int DEN_BITS = 64
) (
   input  logic [DEN_BITS-1:0] rem,
   input  logic                din,
   input  logic [DEN_BITS-1:0] den,
   output logic [DEN_BITS-1:0] rem_out,
   output logic                qbit
);

   logic [DEN_BITS:0] shifted;
   logic [DEN_BITS:0] diff;

   always_comb begin
      shifted = {rem, din};
      diff    = shifted - {1'b0, den};
      qbit    = (shifted >= {1'b0, den});
      rem_out = qbit ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
   end

endmodule

// ===== hw/rtl/complex_arith_unit_core.sv =====
`timescale 1ns / 1ps
// Register order: operands, products, combined products, stage 4, divider stages, output.
// Throughput: one item per cycle if unstalled; the divider is one restoring step per stage.
// Stalls propagate stage by stage, so bubbles close up behind a stalled output.
// Reset clears all valid bits; payload registers are not reset.
module complex_arith_unit_core import cau_pkg::*; #(
   parameter int WORD_BITS = WordBitsDef,
   parameter int FRAC_BITS = FracBitsDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_cmd,
   input  logic signed [WORD_BITS-1:0] req_a_re,
   input  logic signed [WORD_BITS-1:0] req_a_im,
   input  logic signed [WORD_BITS-1:0] req_b_re,
   input  logic signed [WORD_BITS-1:0] req_b_im,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_res_re,
   output logic signed [WORD_BITS-1:0] rsp_res_im,
   output logic                        rsp_is_equal,
   output logic [1:0]                  rsp_status
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int W2 = 2 * WORD_BITS;

   localparam logic [W-1:0] MaxWord = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MinWord = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic          is_div;
      logic [W-1:0]  res_re;
      logic [W-1:0]  res_im;
      logic          eq;
      logic [1:0]    status;
      logic [W2-1:0] rem_re;
      logic [W2-1:0] rem_im;
      logic [W-1:0]  lo_re;
      logic [W-1:0]  lo_im;
      logic [W-1:0]  q_re;
      logic [W-1:0]  q_im;
      logic [W2-1:0] den;
      logic          neg_re;
      logic          neg_im;
      logic          ovf_re;
      logic          ovf_im;
   } dpipe_type;

   function automatic logic [W:0] fit_word(input logic neg, input logic [W2:0] mag,
                                           input logic ovf);
      logic [W2:0]  limit;
      logic         sat;
      logic [W-1:0] val;
      limit = (W2+1)'(MaxWord) + (W2+1)'(neg);
      sat   = ovf || (mag > limit);
      if (sat) begin
         val = neg ? MinWord : MaxWord;
      end else begin
         val = neg ? (W'(0) - mag[W-1:0]) : mag[W-1:0];
      end
      return {sat, val};
   endfunction

   function automatic logic [W:0] fit_sum(input logic [W:0] sum);
      logic sat;
      sat = (sum[W] != sum[W-1]);
      return {sat, sat ? (sum[W] ? MinWord : MaxWord) : sum[W-1:0]};
   endfunction

   // handshake enables
   logic          en1, en2, en3, en_rsp;
   logic [W:0]    en_dv;
   logic [W:0]    dv_valid_ff;
   logic          v1_ff, v2_ff, v3_ff, rsp_valid_ff;

   assign en_rsp    = !rsp_valid_ff || !rsp_stall;
   assign en3       = !v3_ff || en_dv[0];
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   // stage 1: operand register
   logic [2:0]            cmd1_ff;
   logic signed [W-1:0]   ar1_ff, ai1_ff, br1_ff, bi1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
      if (en1 && req_valid) begin
         cmd1_ff <= req_cmd;
         ar1_ff  <= req_a_re;
         ai1_ff  <= req_a_im;
         br1_ff  <= req_b_re;
         bi1_ff  <= req_b_im;
      end
   end

   // stage 2: products, sums, compare
   logic [2:0]           cmd2_ff;
   logic signed [W2-1:0] p_rr_in, p_ii_in, p_ir_in, p_ri_in, p_bb_in, p_cc_in;
   logic signed [W2-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_bb_ff, p_cc_ff;
   logic signed [W:0]    s_re_in, s_im_in, s_re2_ff, s_im2_ff;
   logic                 eq2_ff, bz2_ff;

   always_comb begin
      p_rr_in = ar1_ff * br1_ff;
      p_ii_in = ai1_ff * bi1_ff;
      p_ir_in = ai1_ff * br1_ff;
      p_ri_in = ar1_ff * bi1_ff;
      p_bb_in = br1_ff * br1_ff;
      p_cc_in = bi1_ff * bi1_ff;
      if (cmd1_ff == CMD_SUB) begin
         s_re_in = (W+1)'(ar1_ff) - (W+1)'(br1_ff);
         s_im_in = (W+1)'(ai1_ff) - (W+1)'(bi1_ff);
      end else begin
         s_re_in = (W+1)'(ar1_ff) + (W+1)'(br1_ff);
         s_im_in = (W+1)'(ai1_ff) + (W+1)'(bi1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2 && v1_ff) begin
         cmd2_ff  <= cmd1_ff;
         p_rr_ff  <= p_rr_in;
         p_ii_ff  <= p_ii_in;
         p_ir_ff  <= p_ir_in;
         p_ri_ff  <= p_ri_in;
         p_bb_ff  <= p_bb_in;
         p_cc_ff  <= p_cc_in;
         s_re2_ff <= s_re_in;
         s_im2_ff <= s_im_in;
         eq2_ff   <= (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
         bz2_ff   <= (br1_ff == '0) && (bi1_ff == '0);
      end
   end

   // stage 3: combine products
   logic [2:0]          cmd3_ff;
   logic signed [W2:0]  x_re_in, x_im_in, x_re_ff, x_im_ff;
   logic [W2-1:0]       den_in, den3_ff;
   logic signed [W:0]   s_re3_ff, s_im3_ff;
   logic                eq3_ff, bz3_ff;

   always_comb begin
      if (cmd2_ff == CMD_MUL) begin
         x_re_in = (W2+1)'(p_rr_ff) - (W2+1)'(p_ii_ff);
         x_im_in = (W2+1)'(p_ir_ff) + (W2+1)'(p_ri_ff);
      end else begin
         x_re_in = (W2+1)'(p_rr_ff) + (W2+1)'(p_ii_ff);
         x_im_in = (W2+1)'(p_ir_ff) - (W2+1)'(p_ri_ff);
      end
      den_in = $unsigned(p_bb_ff) + $unsigned(p_cc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3 && v2_ff) begin
         cmd3_ff  <= cmd2_ff;
         x_re_ff  <= x_re_in;
         x_im_ff  <= x_im_in;
         den3_ff  <= den_in;
         s_re3_ff <= s_re2_ff;
         s_im3_ff <= s_im2_ff;
         eq3_ff   <= eq2_ff;
         bz3_ff   <= bz2_ff;
      end
   end

   // stage 4: round and clamp, pass the compare result, or set up the divider
   dpipe_type     d_in;
   dpipe_type     dv_ff [0:W];
   logic [W2:0]   mag_re, mag_im, rnd_re, rnd_im;
   logic [W:0]    fit_re, fit_im;
   logic [W+F-1:0] hi_re, hi_im;

   always_comb begin
      mag_re = x_re_ff[W2] ? ((W2+1)'(0) - x_re_ff) : x_re_ff;
      mag_im = x_im_ff[W2] ? ((W2+1)'(0) - x_im_ff) : x_im_ff;
      rnd_re = (mag_re + ((W2+1)'(1) << (F-1))) >> F;
      rnd_im = (mag_im + ((W2+1)'(1) << (F-1))) >> F;
      hi_re  = mag_re[W2-1:W-F];
      hi_im  = mag_im[W2-1:W-F];
      fit_re = '0;
      fit_im = '0;

      d_in        = '0;
      d_in.den    = den3_ff;
      d_in.neg_re = x_re_ff[W2];
      d_in.neg_im = x_im_ff[W2];
      d_in.rem_re = W2'(hi_re);
      d_in.rem_im = W2'(hi_im);
      d_in.lo_re  = W'(mag_re[W-F-1:0]) << F;
      d_in.lo_im  = W'(mag_im[W-F-1:0]) << F;
      d_in.ovf_re = (W2'(hi_re) >= den3_ff);
      d_in.ovf_im = (W2'(hi_im) >= den3_ff);

      case (cmd3_ff)
         CMD_ADD, CMD_SUB: begin
            fit_re        = fit_sum(s_re3_ff);
            fit_im        = fit_sum(s_im3_ff);
            d_in.res_re   = fit_re[W-1:0];
            d_in.res_im   = fit_im[W-1:0];
            d_in.status   = (fit_re[W] || fit_im[W]) ? ST_SAT : ST_OK;
         end
         CMD_MUL: begin
            fit_re        = fit_word(x_re_ff[W2], rnd_re, 1'b0);
            fit_im        = fit_word(x_im_ff[W2], rnd_im, 1'b0);
            d_in.res_re   = fit_re[W-1:0];
            d_in.res_im   = fit_im[W-1:0];
            d_in.status   = (fit_re[W] || fit_im[W]) ? ST_SAT : ST_OK;
         end
         CMD_DIV: begin
            if (bz3_ff) begin
               d_in.status = ST_DIVZ;
            end else begin
               d_in.is_div = 1'b1;
            end
         end
         CMD_CMP: begin
            d_in.eq = eq3_ff;
         end
         default: begin
            d_in.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en_dv[0]) begin
         dv_valid_ff[0] <= v3_ff;
      end
      if (en_dv[0] && v3_ff) begin
         dv_ff[0] <= d_in;
      end
   end

   // divider stages: one quotient bit per stage per lane
   assign en_dv[W] = !dv_valid_ff[W] || en_rsp;

   for (genvar k = 0; k < W; k++) begin : g_div
      logic [W2-1:0] rem_re_out, rem_im_out;
      logic          qb_re, qb_im;
      dpipe_type     nxt_in;

      assign en_dv[k] = !dv_valid_ff[k] || en_dv[k+1];

      cau_div_step #(.DEN_BITS(W2)) u_step_re (
         .rem     (dv_ff[k].rem_re),
         .din     (dv_ff[k].lo_re[W-1]),
         .den     (dv_ff[k].den),
         .rem_out (rem_re_out),
         .qbit    (qb_re)
      );

      cau_div_step #(.DEN_BITS(W2)) u_step_im (
         .rem     (dv_ff[k].rem_im),
         .din     (dv_ff[k].lo_im[W-1]),
         .den     (dv_ff[k].den),
         .rem_out (rem_im_out),
         .qbit    (qb_im)
      );

      always_comb begin
         nxt_in        = dv_ff[k];
         nxt_in.rem_re = rem_re_out;
         nxt_in.rem_im = rem_im_out;
         nxt_in.lo_re  = dv_ff[k].lo_re << 1;
         nxt_in.lo_im  = dv_ff[k].lo_im << 1;
         nxt_in.q_re   = {dv_ff[k].q_re[W-2:0], qb_re};
         nxt_in.q_im   = {dv_ff[k].q_im[W-2:0], qb_im};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (en_dv[k+1]) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
         if (en_dv[k+1] && dv_valid_ff[k]) begin
            dv_ff[k+1] <= nxt_in;
         end
      end
   end

   // final stage: round quotient, clamp, output register
   dpipe_type    fin;
   logic         inc_re, inc_im;
   logic [W:0]   qf_re, qf_im;
   logic [W-1:0] res_re_in, res_im_in;
   logic [1:0]   status_in;
   logic [W-1:0] res_re_ff, res_im_ff;
   logic         eq_ff;
   logic [1:0]   status_ff;

   always_comb begin
      fin    = dv_ff[W];
      inc_re = ({fin.rem_re, 1'b0} >= {1'b0, fin.den});
      inc_im = ({fin.rem_im, 1'b0} >= {1'b0, fin.den});
      qf_re  = fit_word(fin.neg_re, (W2+1)'({1'b0, fin.q_re}) + (W2+1)'(inc_re), fin.ovf_re);
      qf_im  = fit_word(fin.neg_im, (W2+1)'({1'b0, fin.q_im}) + (W2+1)'(inc_im), fin.ovf_im);
      if (fin.is_div) begin
         res_re_in = qf_re[W-1:0];
         res_im_in = qf_im[W-1:0];
         status_in = (qf_re[W] || qf_im[W]) ? ST_SAT : ST_OK;
      end else begin
         res_re_in = fin.res_re;
         res_im_in = fin.res_im;
         status_in = fin.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_rsp) begin
         rsp_valid_ff <= dv_valid_ff[W];
      end
      if (en_rsp && dv_valid_ff[W]) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         eq_ff     <= fin.eq;
         status_ff <= status_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_re   = res_re_ff;
   assign rsp_res_im   = res_im_ff;
   assign rsp_is_equal = eq_ff;
   assign rsp_status   = status_ff;

endmodule

// ===== bench/complex_arith_unit_core_tb.sv =====
`timescale 1ns / 1ps

module complex_arith_unit_core_tb;
   import cau_pkg::*;

   localparam int WB = WordBitsDef;
   localparam int FB = FracBitsDef;
   localparam int RANDOM_ITEMS = 930;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic signed [127:0] PART_MAX = (128'sd1 <<< (WB - 1)) - 1;
   localparam logic signed [127:0] PART_MIN = -(128'sd1 <<< (WB - 1));
   localparam logic [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
   localparam logic [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};
   localparam logic [WB-1:0] W_ONE = 1 << FB;

   typedef struct {
      logic [2:0]    cmd;
      logic [WB-1:0] a_re, a_im, b_re, b_im;
   } operand_item_type;

   typedef struct {
      logic [WB-1:0] res_re, res_im;
      logic          is_equal;
      logic [1:0]    status;
   } cplx_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_cmd = '0;
   logic signed [WB-1:0] req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [WB-1:0] rsp_res_re, rsp_res_im;
   logic rsp_is_equal;
   logic [1:0] rsp_status;

   operand_item_type pending_items[$];
   cplx_result_type  expected_results[$];
   int sent_count = 0, checked_count = 0, error_count = 0;
   int idle_cycles = 0, total_items = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;
   int cmd_seen[8];

   complex_arith_unit_core dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [127:0] round_product(input logic signed [127:0] v);
      logic signed [127:0] mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (128'sd1 <<< (FB - 1))) >>> FB;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic logic signed [127:0] round_quotient(input logic signed [127:0] num,
                                                          input logic signed [127:0] den);
      logic signed [127:0] mag, q, rm;
      mag = ((num < 0) ? -num : num) <<< FB;
      q = mag / den;
      rm = mag % den;
      if (2 * rm >= den) q = q + 1;
      return (num < 0) ? -q : q;
   endfunction

   function automatic logic [WB-1:0] clamp_part(input logic signed [127:0] v, inout bit sat);
      if (v > PART_MAX) begin
         sat = 1'b1;
         return W_MAX;
      end
      if (v < PART_MIN) begin
         sat = 1'b1;
         return W_MIN;
      end
      return v[WB-1:0];
   endfunction

   function automatic cplx_result_type compute_result(input operand_item_type it);
      cplx_result_type r;
      logic signed [127:0] ar, ai, br, bi, xr, xi, den;
      bit sat;
      ar = $signed(it.a_re);
      ai = $signed(it.a_im);
      br = $signed(it.b_re);
      bi = $signed(it.b_im);
      r = '{default: '0};
      sat = 1'b0;
      case (it.cmd)
         CMD_ADD, CMD_SUB, CMD_MUL: begin
            if (it.cmd == CMD_ADD) begin
               xr = ar + br;
               xi = ai + bi;
            end else if (it.cmd == CMD_SUB) begin
               xr = ar - br;
               xi = ai - bi;
            end else begin
               xr = round_product(ar * br - ai * bi);
               xi = round_product(ai * br + ar * bi);
            end
            r.res_re = clamp_part(xr, sat);
            r.res_im = clamp_part(xi, sat);
            r.status = sat ? ST_SAT : ST_OK;
         end
         CMD_DIV: begin
            if (br == 0 && bi == 0) begin
               r.status = ST_DIVZ;
            end else begin
               den = br * br + bi * bi;
               xr = round_quotient(ar * br + ai * bi, den);
               xi = round_quotient(ai * br - ar * bi, den);
               r.res_re = clamp_part(xr, sat);
               r.res_im = clamp_part(xi, sat);
               r.status = sat ? ST_SAT : ST_OK;
            end
         end
         CMD_CMP: r.is_equal = (it.a_re == it.b_re) && (it.a_im == it.b_im);
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_item(input logic [2:0] cmd, input logic [WB-1:0] a_re, a_im,
                             input logic [WB-1:0] b_re, b_im);
      operand_item_type it;
      it.cmd = cmd;
      it.a_re = a_re;
      it.a_im = a_im;
      it.b_re = b_re;
      it.b_im = b_im;
      pending_items.push_back(it);
   endtask

   function automatic logic [WB-1:0] random_part();
      case ($urandom_range(9))
         0: return W_MAX - $urandom_range(3);
         1: return W_MIN + $urandom_range(3);
         2: return '0;
         3, 4: return $urandom;
         5, 6: return $signed($urandom_range(2 ** 21)) - (2 ** 20);
         default: return $signed($urandom_range(2 ** 25)) - (2 ** 24);
      endcase
   endfunction

   task automatic queue_random_item();
      logic [2:0] cmd;
      logic [WB-1:0] a_re, a_im, b_re, b_im;
      cmd = ($urandom_range(29) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      a_re = random_part();
      a_im = random_part();
      b_re = random_part();
      b_im = random_part();
      if (cmd == CMD_CMP && $urandom_range(2) == 0) begin
         b_re = a_re;
         if ($urandom_range(1)) b_im = a_im;
      end
      if (cmd == CMD_DIV && $urandom_range(9) == 0) begin
         b_re = '0;
         if ($urandom_range(1)) b_im = '0;
      end
      queue_item(cmd, a_re, a_im, b_re, b_im);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(compute_result('{req_cmd, req_a_re, req_a_im,
                                                        req_b_re, req_b_im}));
            cmd_seen[req_cmd]++;
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               operand_item_type it;
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_cmd <= it.cmd;
               req_a_re <= it.a_re;
               req_a_im <= it.a_im;
               req_b_re <= it.b_re;
               req_b_im <= it.b_im;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result re=%h im=%h eq=%b st=%0d", $time,
                        rsp_res_re, rsp_res_im, rsp_is_equal, rsp_status);
               error_count++;
            end else begin
               cplx_result_type e;
               e = expected_results.pop_front();
               if (rsp_res_re !== e.res_re) begin
                  $display("%0t: res_re expected %h actual %h", $time, e.res_re, rsp_res_re);
                  error_count++;
               end
               if (rsp_res_im !== e.res_im) begin
                  $display("%0t: res_im expected %h actual %h", $time, e.res_im, rsp_res_im);
                  error_count++;
               end
               if (rsp_is_equal !== e.is_equal) begin
                  $display("%0t: is_equal expected %b actual %b", $time, e.is_equal,
                           rsp_is_equal);
                  error_count++;
               end
               if (rsp_status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_status);
                  error_count++;
               end
            end
            checked_count++;
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d items outstanding", $time, expected_results.size());
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // switch idle pattern by progress
   always @(posedge clock) begin
      case ((sent_count * 4) / (total_items + 1))
         0: begin
            send_idle_pct <= 0;
            recv_stall_pct <= 0;
         end
         1: begin
            send_idle_pct <= 56;
            recv_stall_pct <= 0;
         end
         2: begin
            send_idle_pct <= 0;
            recv_stall_pct <= 56;
         end
         default: begin
            send_idle_pct <= 8;
            recv_stall_pct <= 8;
         end
      endcase
   end

   initial begin
      queue_item(CMD_ADD, W_MAX, W_MIN, W_MAX, W_MIN);
      queue_item(CMD_ADD, W_MAX, W_MIN, W_MIN, W_MAX);
      queue_item(CMD_ADD, W_ONE, -W_ONE, '0, '0);
      queue_item(CMD_SUB, W_MIN, W_MAX, W_MAX, W_MIN);
      queue_item(CMD_SUB, '0, '0, W_MIN, W_MIN);
      queue_item(CMD_SUB, 32'h0003_8000, 32'hFFFF_0001, 32'h0001_0000, 32'h7FFF_0000);
      queue_item(CMD_MUL, W_MIN, W_MIN, W_MIN, W_MIN);
      queue_item(CMD_MUL, W_MAX, W_MAX, W_MAX, W_MIN);
      queue_item(CMD_MUL, 32'h0000_8000, '0, 32'h0000_0001, '0);
      queue_item(CMD_MUL, 32'hFFFF_8000, '0, 32'h0000_0001, '0);
      queue_item(CMD_MUL, W_ONE, W_ONE, W_ONE, -W_ONE);
      queue_item(CMD_DIV, W_ONE, W_ONE, '0, '0);
      queue_item(CMD_DIV, W_MAX, W_MIN, '0, '0);
      queue_item(CMD_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0002_0000, '0);
      queue_item(CMD_DIV, W_ONE, '0, '0, W_ONE);
      queue_item(CMD_DIV, W_MAX, W_MAX, 32'h0000_0001, '0);
      queue_item(CMD_DIV, W_MIN, W_MIN, W_MIN, W_MIN);
      queue_item(CMD_DIV, 32'h0000_0001, '0, 32'h0003_0000, '0);
      queue_item(CMD_CMP, W_MIN, W_MAX, W_MIN, W_MAX);
      queue_item(CMD_CMP, W_MIN, W_MAX, W_MIN, W_MIN);
      queue_item(CMD_CMP, '0, '0, '0, '0);
      queue_item(3'd5, W_MAX, W_MAX, W_MAX, W_MAX);
      queue_item(3'd6, W_MIN, W_ONE, '0, W_MAX);
      queue_item(3'd7, $urandom, $urandom, $urandom, $urandom);
      repeat (RANDOM_ITEMS) queue_random_item();
      total_items = pending_items.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (pending_items.size() == 0 && sent_count == total_items);
      wait (expected_results.size() == 0);
      repeat (WB + 20) @(posedge clock);

      $display("Sent %0d items, checked %0d results: add %0d sub %0d mul %0d div %0d cmp %0d",
               sent_count, checked_count, cmd_seen[CMD_ADD], cmd_seen[CMD_SUB],
               cmd_seen[CMD_MUL], cmd_seen[CMD_DIV], cmd_seen[CMD_CMP]);
      $display("Idle phases covered: none, sender 56%%, receiver 56%%, both 8%%; %0d errors",
               error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
